/* hw/rtl/nlcc_pkg.sv */
// shared types and constants of the nearest lab color classifier
package nlcc_pkg;

  localparam int unsigned IDX_W  = 4;
  localparam int unsigned L_W    = 7;
  localparam int unsigned AB_W   = 8;
  localparam int unsigned DIST_W = 18;
  localparam int unsigned SQ_W   = 16;
  localparam int unsigned COLOR_W = L_W + 2 * AB_W;

  typedef enum logic {
    OP_WRITE = 1'b0,
    OP_QUERY = 1'b1
  } opcode_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic                   is_query;
    logic                   slot_ok;
    logic [IDX_W-1:0]       index;
    logic                   entry_valid;
    logic [L_W-1:0]         lightness;
    logic signed [AB_W-1:0] green_red;
    logic signed [AB_W-1:0] blue_yellow;
  } cmd_t;

  typedef struct packed {
    logic [IDX_W-1:0]  index;
    logic [DIST_W-1:0] distance;
    logic              empty;
  } res_t;

endpackage

/* hw/rtl/nearest_lab_color_classifier_top.sv */
// top level of the nearest lab color classifier
//
// input queue: an item is taken at a clock edge with push_i high and full_o
// low. opcode_i low writes entry_index_i with the color and entry_valid_i,
// opcode_i high queries the nearest valid entry to the given sample.
// result queue: while empty_o is low the oldest result is on the result
// ports; it is taken at a clock edge with pop_i high. only queries give a
// result. ties go to the lower entry index; table_empty_o flags a query that
// found no valid entry, with index and distance zero.
// a two-entry command queue sits in front of the table engine, so inputs
// are taken while the engine works or a result waits.
// a write is handled in the engine's idle state. a query occupies the engine
// for a scan with one table read per cycle through the single read port of
// the color ram, a read, square and compare pipeline, and a load of the
// result register.
// reset clears all valid bits and both queues; colors need no clearing.
// if the receiver stalls, the finished query holds in the engine and the
// command queue fills, after which full_o stays high.
module nearest_lab_color_classifier_top #(
  parameter int unsigned ENTRIES = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              push_i,
  output logic                              full_o,
  input  logic                              opcode_i,
  input  logic [nlcc_pkg::IDX_W-1:0]        entry_index_i,
  input  logic                              entry_valid_i,
  input  logic [nlcc_pkg::L_W-1:0]          lightness_i,
  input  logic signed [nlcc_pkg::AB_W-1:0]  green_red_i,
  input  logic signed [nlcc_pkg::AB_W-1:0]  blue_yellow_i,
  output logic                              empty_o,
  input  logic                              pop_i,
  output logic [nlcc_pkg::IDX_W-1:0]        nearest_index_o,
  output logic [nlcc_pkg::DIST_W-1:0]       nearest_distance_o,
  output logic                              table_empty_o
);

  logic           cmd_valid, cmd_take;
  nlcc_pkg::cmd_t cmd;

  nlcc_front #(
    .ENTRIES(ENTRIES)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push_i),
    .full_o       (full_o),
    .opcode_i     (opcode_i),
    .entry_index_i(entry_index_i),
    .entry_valid_i(entry_valid_i),
    .lightness_i  (lightness_i),
    .green_red_i  (green_red_i),
    .blue_yellow_i(blue_yellow_i),
    .cmd_valid_o  (cmd_valid),
    .cmd_o        (cmd),
    .cmd_take_i   (cmd_take)
  );

  nlcc_back #(
    .ENTRIES(ENTRIES)
  ) u_back (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_valid_i       (cmd_valid),
    .cmd_i             (cmd),
    .cmd_take_o        (cmd_take),
    .empty_o           (empty_o),
    .pop_i             (pop_i),
    .nearest_index_o   (nearest_index_o),
    .nearest_distance_o(nearest_distance_o),
    .table_empty_o     (table_empty_o)
  );

endmodule

/* hw/rtl/nlcc_ram.sv */
// generic simple dual-port ram with registered read
module nlcc_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                                    clk_i,
  input  logic                                    we_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                        wdata_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                        rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* hw/rtl/nlcc_front.sv */
// front end: input beat decode and two-entry command queue
module nlcc_front #(
  parameter int unsigned ENTRIES = 16
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 push_i,
  output logic                                 full_o,
  input  logic                                 opcode_i,
  input  logic [nlcc_pkg::IDX_W-1:0]           entry_index_i,
  input  logic                                 entry_valid_i,
  input  logic [nlcc_pkg::L_W-1:0]             lightness_i,
  input  logic signed [nlcc_pkg::AB_W-1:0]     green_red_i,
  input  logic signed [nlcc_pkg::AB_W-1:0]     blue_yellow_i,
  output logic                                 cmd_valid_o,
  output nlcc_pkg::cmd_t                       cmd_o,
  input  logic                                 cmd_take_i
);

  nlcc_pkg::cmd_t fifo_q [2];
  nlcc_pkg::cmd_t cmd_in;
  logic           wptr_q, wptr_d, rptr_q, rptr_d;
  logic [1:0]     count_q, count_d;
  logic           do_push, do_pop;

  always_comb begin
    cmd_in.is_query    = (opcode_i == nlcc_pkg::OP_QUERY);
    cmd_in.slot_ok     = (32'(entry_index_i) < 32'(ENTRIES));
    cmd_in.index       = entry_index_i;
    cmd_in.entry_valid = entry_valid_i;
    cmd_in.lightness   = lightness_i;
    cmd_in.green_red   = green_red_i;
    cmd_in.blue_yellow = blue_yellow_i;
  end

  assign full_o      = (count_q == 2'd2);
  assign cmd_valid_o = (count_q != 2'd0);
  assign cmd_o       = fifo_q[rptr_q];
  assign do_push     = push_i && !full_o;
  assign do_pop      = cmd_take_i && cmd_valid_o;

  always_comb begin
    wptr_d  = do_push ? !wptr_q : wptr_q;
    rptr_d  = do_pop ? !rptr_q : rptr_q;
    count_d = count_q + 2'(do_push) - 2'(do_pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= 1'b0;
      rptr_q  <= 1'b0;
      count_q <= 2'd0;
    end else begin
      wptr_q  <= wptr_d;
      rptr_q  <= rptr_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      fifo_q[wptr_q] <= cmd_in;
    end
  end

endmodule

/* hw/rtl/nlcc_back.sv */
// back end: table update, nearest entry scan and result register
module nlcc_back #(
  parameter int unsigned ENTRIES = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cmd_valid_i,
  input  nlcc_pkg::cmd_t                    cmd_i,
  output logic                              cmd_take_o,
  output logic                              empty_o,
  input  logic                              pop_i,
  output logic [nlcc_pkg::IDX_W-1:0]        nearest_index_o,
  output logic [nlcc_pkg::DIST_W-1:0]       nearest_distance_o,
  output logic                              table_empty_o
);

  localparam int unsigned IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam logic [IW-1:0] LAST = IW'(ENTRIES - 1);

  nlcc_pkg::state_e state_q, state_d;

  logic [ENTRIES-1:0] valid_q;
  logic [IW-1:0]      cnt_q, cnt_d;
  nlcc_pkg::cmd_t     smp_q;

  logic                        ram_we;
  logic [nlcc_pkg::COLOR_W-1:0] ram_wdata, ram_rdata;
  logic                        start, issue, load_out;

  logic          s1_vld_q, s1_ok_q;
  logic [IW-1:0] s1_idx_q;
  logic          s2_vld_q, s2_ok_q;
  logic [IW-1:0] s2_idx_q;
  logic [nlcc_pkg::SQ_W-1:0] sq_l_q, sq_a_q, sq_b_q;
  logic [nlcc_pkg::SQ_W-1:0] sq_l_d, sq_a_d, sq_b_d;

  logic                          found_q;
  logic [IW-1:0]                 best_idx_q;
  logic [nlcc_pkg::DIST_W-1:0]   best_dist_q, sum;
  logic                          take_best;

  logic           out_vld_q;
  nlcc_pkg::res_t out_q, out_d;

  logic [nlcc_pkg::L_W-1:0]     ref_l;
  logic signed [nlcc_pkg::AB_W-1:0] ref_a, ref_b;
  logic signed [8:0]  dl, da, db;
  logic signed [17:0] pl, pa, pb;

  assign ram_wdata = {cmd_i.lightness, cmd_i.green_red, cmd_i.blue_yellow};

  nlcc_ram #(
    .WIDTH(nlcc_pkg::COLOR_W),
    .DEPTH(ENTRIES)
  ) u_color_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(IW'(cmd_i.index)),
    .wdata_i(ram_wdata),
    .raddr_i(cnt_q),
    .rdata_o(ram_rdata)
  );

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      nlcc_pkg::ST_IDLE: begin
        if (cmd_valid_i && cmd_i.is_query) begin
          state_d = nlcc_pkg::ST_SCAN;
        end
      end
      nlcc_pkg::ST_SCAN: begin
        if (cnt_q == LAST) begin
          state_d = nlcc_pkg::ST_DRAIN;
        end
      end
      nlcc_pkg::ST_DRAIN: begin
        if (!s1_vld_q && !s2_vld_q) begin
          state_d = nlcc_pkg::ST_DONE;
        end
      end
      nlcc_pkg::ST_DONE: begin
        if (!out_vld_q || pop_i) begin
          state_d = nlcc_pkg::ST_IDLE;
        end
      end
      default: state_d = nlcc_pkg::ST_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    cmd_take_o = 1'b0;
    ram_we     = 1'b0;
    start      = 1'b0;
    issue      = 1'b0;
    load_out   = 1'b0;
    case (state_q)
      nlcc_pkg::ST_IDLE: begin
        cmd_take_o = cmd_valid_i;
        ram_we     = cmd_valid_i && !cmd_i.is_query && cmd_i.slot_ok;
        start      = cmd_valid_i && cmd_i.is_query;
      end
      nlcc_pkg::ST_SCAN: begin
        issue = 1'b1;
      end
      nlcc_pkg::ST_DRAIN: begin
      end
      nlcc_pkg::ST_DONE: begin
        load_out = !out_vld_q || pop_i;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    cnt_d = cnt_q;
    if (start) begin
      cnt_d = '0;
    end else if (issue && cnt_q != LAST) begin
      cnt_d = cnt_q + 1'b1;
    end
  end

  // squared terms of the distance of the entry read in the previous cycle
  always_comb begin
    {ref_l, ref_a, ref_b} = ram_rdata;
    dl = $signed({2'b00, smp_q.lightness}) - $signed({2'b00, ref_l});
    da = 9'(smp_q.green_red) - 9'(ref_a);
    db = 9'(smp_q.blue_yellow) - 9'(ref_b);
    pl = dl * dl;
    pa = da * da;
    pb = db * db;
    sq_l_d = pl[nlcc_pkg::SQ_W-1:0];
    sq_a_d = pa[nlcc_pkg::SQ_W-1:0];
    sq_b_d = pb[nlcc_pkg::SQ_W-1:0];
  end

  assign sum = nlcc_pkg::DIST_W'(sq_l_q) + nlcc_pkg::DIST_W'(sq_a_q)
             + nlcc_pkg::DIST_W'(sq_b_q);
  assign take_best = s2_vld_q && s2_ok_q && (!found_q || sum < best_dist_q);

  always_comb begin
    out_d.index    = found_q ? nlcc_pkg::IDX_W'(best_idx_q) : '0;
    out_d.distance = found_q ? best_dist_q : '0;
    out_d.empty    = !found_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= nlcc_pkg::ST_IDLE;
      valid_q   <= '0;
      cnt_q     <= '0;
      s1_vld_q  <= 1'b0;
      s2_vld_q  <= 1'b0;
      found_q   <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      cnt_q    <= cnt_d;
      s1_vld_q <= issue;
      s2_vld_q <= s1_vld_q;
      if (ram_we) begin
        valid_q[IW'(cmd_i.index)] <= cmd_i.entry_valid;
      end
      if (start) begin
        found_q <= 1'b0;
      end else if (take_best) begin
        found_q <= 1'b1;
      end
      if (load_out) begin
        out_vld_q <= 1'b1;
      end else if (pop_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start) begin
      smp_q <= cmd_i;
    end
    s1_ok_q  <= valid_q[cnt_q];
    s1_idx_q <= cnt_q;
    s2_ok_q  <= s1_ok_q;
    s2_idx_q <= s1_idx_q;
    sq_l_q   <= sq_l_d;
    sq_a_q   <= sq_a_d;
    sq_b_q   <= sq_b_d;
    if (take_best) begin
      best_idx_q  <= s2_idx_q;
      best_dist_q <= sum;
    end
    if (load_out) begin
      out_q <= out_d;
    end
  end

  assign empty_o            = !out_vld_q;
  assign nearest_index_o    = out_q.index;
  assign nearest_distance_o = out_q.distance;
  assign table_empty_o      = out_q.empty;

endmodule
